// ===== rtl/cdm_pkg.sv =====
// shared constants and types for the clock divider / multiplier
`default_nettype none
package cdm_pkg;

  // default sizes
  localparam int unsigned LANES_DEF      = 8;
  localparam int unsigned COUNT_BITS_DEF = 24;

  // fixed field widths
  localparam int unsigned GATE_W  = 8;
  localparam int unsigned LEVEL_W = 2;
  // widest lane factor (lane number plus one, up to 31)
  localparam int unsigned FACTOR_W = 5;
  // wide enough for lane number plus rotation
  localparam int unsigned DST_W = 5;

  // clock level codes
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_POS  = 2'd1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLY_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 1'b1;

  // control from the sequencing logic to every lane
  typedef struct packed {
    logic step;
    logic run;
    logic multiply;
    logic armed;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/cdm_control.sv =====
// edge detection, period measurement, arming and rotation state
`default_nettype none
module cdm_control #(
  parameter int unsigned LANES      = cdm_pkg::LANES_DEF,
  parameter int unsigned COUNT_BITS = cdm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic                            run,
  input  wire logic                            multiply,
  input  wire logic                            reset_high,
  input  wire logic                            rotate_high,
  input  wire logic [cdm_pkg::LEVEL_W-1:0]     clock_level,
  output cdm_pkg::lane_ctl_t                   ctl,
  output logic [COUNT_BITS-1:0]                period,
  output logic [$clog2(LANES)-1:0]             rotation_now
);

  localparam int unsigned LANE_W = $clog2(LANES);

  logic [LANE_W-1:0]     rotation, rotation_next, rotation_base;
  logic                  rotate_latch, rotate_latch_next;
  logic                  clock_latch, clock_latch_next;
  logic                  period_running, period_running_next;
  logic                  seen_edge, seen_edge_next;
  logic                  armed, armed_next;
  logic [COUNT_BITS-1:0] period_count, period_count_next, period_base;
  logic [COUNT_BITS-1:0] last_period, last_period_next;
  logic                  clock_rise;

  // next state for one request
  always_comb begin
    rotation_base = reset_high ? '0 : rotation;
    if (rotate_high && !rotate_latch) begin
      rotation_next = (rotation_base == LANE_W'(LANES - 1)) ? '0 : rotation_base + 1'b1;
    end else begin
      rotation_next = rotation_base;
    end
    rotate_latch_next = rotate_high;

    clock_rise = (clock_level == cdm_pkg::LEVEL_POS) && !clock_latch;
    if (clock_level == cdm_pkg::LEVEL_POS) begin
      clock_latch_next = 1'b1;
    end else if (clock_level == cdm_pkg::LEVEL_ZERO) begin
      clock_latch_next = 1'b0;
    end else begin
      clock_latch_next = clock_latch;
    end

    period_running_next = period_running | clock_rise;
    last_period_next    = clock_rise ? period_count : last_period;
    armed_next          = armed | (clock_rise & seen_edge);
    seen_edge_next      = seen_edge | clock_rise;

    // period count restarts on a rising clock and saturates
    period_base = clock_rise ? '0 : period_count;
    if (period_running_next && (period_base != '1)) begin
      period_count_next = period_base + 1'b1;
    end else begin
      period_count_next = period_base;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation       <= '0;
      rotate_latch   <= 1'b0;
      clock_latch    <= 1'b0;
      period_running <= 1'b0;
      seen_edge      <= 1'b0;
      armed          <= 1'b0;
      period_count   <= '0;
      last_period    <= '0;
    end else if (step) begin
      rotation       <= rotation_next;
      rotate_latch   <= rotate_latch_next;
      clock_latch    <= clock_latch_next;
      period_running <= period_running_next;
      seen_edge      <= seen_edge_next;
      armed          <= armed_next;
      period_count   <= period_count_next;
      last_period    <= last_period_next;
    end
  end

  // lanes see this request's updated values
  assign ctl.step     = step;
  assign ctl.run      = run;
  assign ctl.multiply = multiply;
  assign ctl.armed    = armed_next;
  assign period       = last_period_next;
  assign rotation_now = rotation_next;

endmodule
`default_nettype wire

// ===== rtl/cdm_lane.sv =====
// one lane: sample counter with divide or multiply threshold
`default_nettype none
module cdm_lane #(
  parameter int unsigned LANE_NUM   = 0,
  parameter int unsigned COUNT_BITS = cdm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cdm_pkg::lane_ctl_t    ctl,
  input  wire logic [COUNT_BITS-1:0] period,
  output logic                       fire
);

  localparam int unsigned PROD_W = COUNT_BITS + cdm_pkg::FACTOR_W;
  localparam logic [PROD_W-1:0] FACTOR = PROD_W'(LANE_NUM + 1);

  logic [COUNT_BITS-1:0] count, count_next;
  logic [PROD_W-1:0]     count_wide, period_wide;
  logic                  exceeds;

  // count > period/n is the same test as count*n > period
  always_comb begin
    count_wide  = PROD_W'(count);
    period_wide = PROD_W'(period);
    if (ctl.multiply) begin
      exceeds = (count_wide * FACTOR) > period_wide;
    end else begin
      exceeds = count_wide > (period_wide * FACTOR);
    end
    fire = ctl.run && ctl.armed && exceeds;
    if (fire) begin
      count_next = '0;
    end else if (count != '1) begin
      count_next = count + 1'b1;
    end else begin
      count_next = count;
    end
  end

  // counter holds while the lanes are stopped
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.step && ctl.run) begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/clock_divider_multiplier.sv =====
// top level: request and result registers, configuration, lanes and output rotation
// an accepted request passes from the request register to the result register
// throughput: one request per cycle while results are taken; the result register frees as it is taken
// all state lives in one pass of logic between the two registers
// reset: synchronous; clears both registers' valid, configuration and all counters
`default_nettype none
module clock_divider_multiplier #(
  parameter int unsigned LANES      = cdm_pkg::LANES_DEF,
  parameter int unsigned COUNT_BITS = cdm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [cdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic                              cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              reset_high,
  input  wire logic                              rotate_high,
  input  wire logic [cdm_pkg::LEVEL_W-1:0]       clock_level,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [cdm_pkg::GATE_W-1:0]             gate_outputs
);

  localparam int unsigned LANE_W = $clog2(LANES);

  logic                          multiply_mode;
  logic                          enable;
  logic                          req_valid;
  logic                          req_reset;
  logic                          req_rotate;
  logic [cdm_pkg::LEVEL_W-1:0]   req_level;
  logic                          advance;
  cdm_pkg::lane_ctl_t            ctl;
  logic [COUNT_BITS-1:0]         period;
  logic [LANE_W-1:0]             rotation_now;
  logic [LANES-1:0]              fire;
  logic [cdm_pkg::GATE_W-1:0]    gates;
  logic [cdm_pkg::DST_W-1:0]     dst;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      multiply_mode <= 1'b0;
      enable        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdm_pkg::REG_MULTIPLY_MODE: multiply_mode <= cfg_data;
        cdm_pkg::REG_ENABLE:        enable        <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: process when the result register is free or being taken
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_reset  <= reset_high;
      req_rotate <= rotate_high;
      req_level  <= clock_level;
    end
  end

  // shared sequencing state
  cdm_control #(
    .LANES      (LANES),
    .COUNT_BITS (COUNT_BITS)
  ) u_control (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .run          (enable),
    .multiply     (multiply_mode),
    .reset_high   (req_reset),
    .rotate_high  (req_rotate),
    .clock_level  (req_level),
    .ctl          (ctl),
    .period       (period),
    .rotation_now (rotation_now)
  );

  // lanes
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    cdm_lane #(
      .LANE_NUM   (k),
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .period (period),
      .fire   (fire[k])
    );
  end

  // lane k drives output (k + rotation) mod LANES; outputs past the eighth are dropped
  always_comb begin
    gates = '0;
    dst   = '0;
    for (int k = 0; k < LANES; k++) begin
      dst = cdm_pkg::DST_W'(k) + cdm_pkg::DST_W'(rotation_now);
      if (dst >= cdm_pkg::DST_W'(LANES)) begin
        dst = dst - cdm_pkg::DST_W'(LANES);
      end
      if (fire[k] && (dst < cdm_pkg::DST_W'(cdm_pkg::GATE_W))) begin
        gates[dst[2:0]] = 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gate_outputs <= gates;
    end
  end

endmodule
`default_nettype wire
